// ----- hw/rtl/bmm_pkg.sv -----
// Shared types and constants of the block min/max/RMS level meter.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bmm_pkg;

    localparam int MAX_BLOCK_LEN = 4096;
    localparam int CNT_W         = $clog2(MAX_BLOCK_LEN) + 1;
    localparam int SQ_W          = 31;   // square of a Q1.15 magnitude, at most 2^30
    localparam int SUM_W         = SQ_W + $clog2(MAX_BLOCK_LEN);
    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = SAMPLE_W + 1;
    localparam int PEAK_W        = 17;
    localparam int OUT_W         = 16;
    localparam int BLKNUM_W      = 32;

    localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(32768);

    // block record queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // back end iterations
    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_IN_W  = 32;
    localparam int SQRT_STEPS = ROOT_IN_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int DREM_W     = CNT_W;
    localparam int SREM_W     = OUT_W + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED     = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] blk_min;
        logic signed [SAMPLE_W-1:0] blk_max;
        logic [SUM_W-1:0]           sum;
        logic [CNT_W-1:0]           cnt;
        logic [OUT_W-1:0]           peak;
        logic [BLKNUM_W-1:0]        num;
    } t_blk;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } t_q_status;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_SQRT,
        BS_DONE
    } t_back_state;

    function automatic logic [MAG_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? (MAG_W'(0) - ext) : ext;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bmm_front.sv -----
// Front end: takes samples, squares them, keeps the running block statistics
// and pushes one record per finished block. Depends on bmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmm_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire signed [bmm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                i_last,
    input  wire                                i_auto_scale,
    input  wire                                i_paused,
    input  bmm_pkg::t_q_status                 i_q_status,
    output logic                               o_push,
    output bmm_pkg::t_blk                      o_blk
);

    logic                                 accept;
    logic signed [2*bmm_pkg::SAMPLE_W-1:0] square;

    logic                                 r_v;
    logic                                 r_last;
    logic signed [bmm_pkg::SAMPLE_W-1:0]  r_s;
    logic [bmm_pkg::SQ_W-1:0]             r_sq;

    logic signed [bmm_pkg::SAMPLE_W-1:0]  r_min;
    logic signed [bmm_pkg::SAMPLE_W-1:0]  r_max;
    logic [bmm_pkg::SUM_W-1:0]            r_sum;
    logic [bmm_pkg::CNT_W-1:0]            r_cnt;
    logic [bmm_pkg::PEAK_W-1:0]           r_peak;
    logic [bmm_pkg::BLKNUM_W-1:0]         r_blocks;

    logic signed [bmm_pkg::SAMPLE_W-1:0]  n_min;
    logic signed [bmm_pkg::SAMPLE_W-1:0]  n_max;
    logic [bmm_pkg::SUM_W-1:0]            n_sum;
    logic [bmm_pkg::CNT_W-1:0]            n_cnt;
    logic [bmm_pkg::PEAK_W-1:0]           n_peak;
    logic [bmm_pkg::MAG_W-1:0]            mag_min;
    logic [bmm_pkg::MAG_W-1:0]            mag_max;
    logic [bmm_pkg::MAG_W-1:0]            mag_big;
    logic                                 first;
    logic                                 room;

    // Keep one slot free for the item already in the square stage.
    assign o_stall = i_q_status.almost_full;
    assign accept  = i_valid && !o_stall;
    assign square  = (2*bmm_pkg::SAMPLE_W)'(i_sample) * (2*bmm_pkg::SAMPLE_W)'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= accept && !i_paused;
        end
        if (accept) begin
            r_s    <= i_sample;
            r_last <= i_last;
            r_sq   <= square[bmm_pkg::SQ_W-1:0];
        end
    end

    always_comb begin
        first   = (r_cnt == '0);
        room    = (r_cnt < bmm_pkg::CNT_W'(bmm_pkg::MAX_BLOCK_LEN));
        n_min   = (first || (r_s < r_min)) ? r_s : r_min;
        n_max   = (first || (r_s > r_max)) ? r_s : r_max;
        n_sum   = room ? (r_sum + bmm_pkg::SUM_W'(r_sq)) : r_sum;
        n_cnt   = room ? (r_cnt + 1'b1) : r_cnt;
        mag_min = bmm_pkg::mag16(n_min);
        mag_max = bmm_pkg::mag16(n_max);
        mag_big = (mag_max > mag_min) ? mag_max : mag_min;
        n_peak  = (i_auto_scale && (bmm_pkg::PEAK_W'(mag_big) > r_peak))
                  ? bmm_pkg::PEAK_W'(mag_big) : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_cnt    <= '0;
            r_peak   <= bmm_pkg::PEAK_RESET;
            r_blocks <= '0;
        end else if (r_v) begin
            if (r_last) begin
                r_sum    <= '0;
                r_cnt    <= '0;
                r_peak   <= n_peak;
                r_blocks <= r_blocks + 1'b1;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_push        = r_v && r_last;
    assign o_blk.blk_min = n_min;
    assign o_blk.blk_max = n_max;
    assign o_blk.sum     = n_sum;
    assign o_blk.cnt     = n_cnt;
    assign o_blk.peak    = n_peak[bmm_pkg::OUT_W-1:0];
    assign o_blk.num     = r_blocks;

endmodule

`default_nettype wire

// ----- hw/rtl/bmm_queue.sv -----
// Short queue of finished block records between front and back end.
// Depends on bmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmm_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  bmm_pkg::t_blk       i_blk,
    input  wire                 i_pop,
    output bmm_pkg::t_blk       o_blk,
    output bmm_pkg::t_q_status  o_status
);

    bmm_pkg::t_blk                r_mem [bmm_pkg::Q_DEPTH];
    logic [bmm_pkg::Q_PTR_W-1:0]  r_wr;
    logic [bmm_pkg::Q_PTR_W-1:0]  r_rd;
    logic [bmm_pkg::Q_CNT_W-1:0]  r_count;
    logic                         do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

    assign o_blk                = r_mem[r_rd];
    assign o_status.empty       = (r_count == '0);
    assign o_status.almost_full = (r_count >= bmm_pkg::Q_CNT_W'(bmm_pkg::Q_DEPTH - 1));

endmodule

`default_nettype wire

// ----- hw/rtl/bmm_back.sv -----
// Back end: per block, divides the sum of squares by the count one bit a cycle,
// takes the integer square root two bits a cycle and holds the result.
// Depends on bmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmm_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  bmm_pkg::t_q_status                  i_q_status,
    input  bmm_pkg::t_blk                       i_blk,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic signed [bmm_pkg::SAMPLE_W-1:0] o_block_min,
    output logic signed [bmm_pkg::SAMPLE_W-1:0] o_block_max,
    output logic [bmm_pkg::OUT_W-1:0]           o_block_rms,
    output logic [bmm_pkg::OUT_W-1:0]           o_peak_amplitude,
    output logic [bmm_pkg::BLKNUM_W-1:0]        o_block_number
);

    bmm_pkg::t_back_state             r_state;
    bmm_pkg::t_back_state             n_state;
    logic [bmm_pkg::STEP_W-1:0]       r_step;
    bmm_pkg::t_blk                    r_rec;

    logic [bmm_pkg::SUM_W-1:0]        r_dvd;
    logic [bmm_pkg::DREM_W-1:0]       r_drem;
    logic [bmm_pkg::ROOT_IN_W-1:0]    r_x;
    logic [bmm_pkg::SREM_W-1:0]       r_srem;
    logic [bmm_pkg::OUT_W-1:0]        r_root;
    logic                             r_out_valid;

    logic                             div_last;
    logic                             sqrt_last;
    logic                             load_out;

    logic [bmm_pkg::DREM_W:0]         drem_sh;
    logic                             d_ge;
    logic [bmm_pkg::DREM_W:0]         drem_nx;
    logic [bmm_pkg::SUM_W-1:0]        n_dvd;

    logic [bmm_pkg::SREM_W+1:0]       srem_sh;
    logic [bmm_pkg::SREM_W+1:0]       trial;
    logic                             s_ge;
    logic [bmm_pkg::SREM_W+1:0]       srem_nx;

    assign div_last  = (r_step == bmm_pkg::STEP_W'(bmm_pkg::DIV_STEPS - 1));
    assign sqrt_last = (r_step == bmm_pkg::STEP_W'(bmm_pkg::SQRT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            bmm_pkg::BS_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = bmm_pkg::BS_DIV;
                end
            end
            bmm_pkg::BS_DIV: begin
                if (div_last) begin
                    n_state = bmm_pkg::BS_SQRT;
                end
            end
            bmm_pkg::BS_SQRT: begin
                if (sqrt_last) begin
                    n_state = bmm_pkg::BS_DONE;
                end
            end
            bmm_pkg::BS_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = bmm_pkg::BS_IDLE;
                end
            end
            default: n_state = bmm_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            bmm_pkg::BS_IDLE: o_pop    = !i_q_status.empty;
            bmm_pkg::BS_DONE: load_out = !r_out_valid || !i_stall;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // restoring division step
    always_comb begin
        drem_sh = {r_drem, r_dvd[bmm_pkg::SUM_W-1]};
        d_ge    = (drem_sh >= {1'b0, r_rec.cnt});
        drem_nx = d_ge ? (drem_sh - {1'b0, r_rec.cnt}) : drem_sh;
        n_dvd   = {r_dvd[bmm_pkg::SUM_W-2:0], d_ge};
    end

    // square root step
    always_comb begin
        srem_sh = {r_srem, r_x[bmm_pkg::ROOT_IN_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        s_ge    = (srem_sh >= trial);
        srem_nx = s_ge ? (srem_sh - trial) : srem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmm_pkg::BS_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_step <= '0;
            end else if ((r_state == bmm_pkg::BS_DIV) || (r_state == bmm_pkg::BS_SQRT)) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bmm_pkg::BS_IDLE: begin
                r_rec  <= i_blk;
                r_dvd  <= i_blk.sum;
                r_drem <= '0;
            end
            bmm_pkg::BS_DIV: begin
                r_dvd  <= n_dvd;
                r_drem <= drem_nx[bmm_pkg::DREM_W-1:0];
                if (div_last) begin
                    // quotient is at most 2^30, so its low word is all of it
                    r_x    <= n_dvd[bmm_pkg::ROOT_IN_W-1:0];
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            bmm_pkg::BS_SQRT: begin
                r_x    <= {r_x[bmm_pkg::ROOT_IN_W-3:0], 2'b00};
                r_srem <= srem_nx[bmm_pkg::SREM_W-1:0];
                r_root <= {r_root[bmm_pkg::OUT_W-2:0], s_ge};
            end
            default: begin
                r_dvd <= r_dvd;
            end
        endcase
        if (load_out) begin
            o_block_min      <= r_rec.blk_min;
            o_block_max      <= r_rec.blk_max;
            o_block_rms      <= r_root;
            o_peak_amplitude <= r_rec.peak;
            o_block_number   <= r_rec.num;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- hw/rtl/block_min_max_rms_peak.sv -----
// Block level meter: min, max, RMS and peak of blocks of Q1.15 audio samples.
// Top level; depends on bmm_pkg, bmm_front, bmm_queue and bmm_back.
//
// Input channel (i_valid / o_stall): one signed sample per item, i_last set on
// the final sample of a block. Samples are taken one per cycle; o_stall rises
// only while the block record queue is nearly full.
// Output channel (o_valid / i_stall): one result per block, carrying min, max,
// floor RMS, running peak magnitude and the block number.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
// auto_scale, index 1 is paused. While paused, samples are taken and dropped.
// The last sample of a block is squared and its record is pushed into the queue;
// the back end pops it, runs 43 division steps of one quotient bit and 16 root
// steps of two bits, then loads the output register and raises o_valid. It takes
// one block at a time; blocks arriving faster queue up in the four-entry queue
// and then stall the input. Samples run at one per cycle while o_stall is low.
// When the receiver stalls, the result register holds; the back end finishes
// the next block and waits, and the front keeps filling the queue.
// Synchronous reset clears the statistics, the queue and the output valid;
// auto_scale resets to 1, paused to 0, the peak to 32768.
`timescale 1ns / 1ps
`default_nettype none

module block_min_max_rms_peak (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire signed [bmm_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                 i_last,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic signed [bmm_pkg::SAMPLE_W-1:0] o_block_min,
    output logic signed [bmm_pkg::SAMPLE_W-1:0] o_block_max,
    output logic [bmm_pkg::OUT_W-1:0]           o_block_rms,
    output logic [bmm_pkg::OUT_W-1:0]           o_peak_amplitude,
    output logic [bmm_pkg::BLKNUM_W-1:0]        o_block_number,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [bmm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire                                 i_cfg_data
);

    logic               r_auto_scale;
    logic               r_paused;
    logic               push;
    logic               pop;
    bmm_pkg::t_blk      front_blk;
    bmm_pkg::t_blk      q_blk;
    bmm_pkg::t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_scale <= 1'b1;
            r_paused     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmm_pkg::CFG_AUTO_SCALE: r_auto_scale <= i_cfg_data;
                bmm_pkg::CFG_PAUSED:     r_paused     <= i_cfg_data;
                default: begin
                    r_auto_scale <= r_auto_scale;
                end
            endcase
        end
    end

    bmm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .i_auto_scale (r_auto_scale),
        .i_paused     (r_paused),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_blk        (front_blk)
    );

    bmm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_blk    (front_blk),
        .i_pop    (pop),
        .o_blk    (q_blk),
        .o_status (q_status)
    );

    bmm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_status       (q_status),
        .i_blk            (q_blk),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_block_min      (o_block_min),
        .o_block_max      (o_block_max),
        .o_block_rms      (o_block_rms),
        .o_peak_amplitude (o_peak_amplitude),
        .o_block_number   (o_block_number)
    );

endmodule

`default_nettype wire
